// ----- hdl/lpr_pkg.sv -----
// Shared types and constants for the line pixel rasteriser.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int ROW_BITS       = 10;
    localparam int DIM_BITS       = 11;
    localparam int ADDR_BITS      = 20;
    localparam int COLOR_BITS     = 24;
    localparam int CFG_IDX_BITS   = 2;
    localparam int OUT_TDATA_BITS = ((2 * ROW_BITS + ADDR_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic                MODE_START       = 1'b0;
    localparam logic                MODE_ADVANCE     = 1'b1;
    localparam logic                ORIENT_LANDSCAPE = 1'b1;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET      = DIM_BITS'(800);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET     = DIM_BITS'(480);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIENT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                orientation;
        logic [DIM_BITS-1:0] panel_width;
        logic [DIM_BITS-1:0] panel_height;
    } t_cfg;

endpackage

// ----- hdl/line_pixel_rasterizer.sv -----
// A pixel is registered in the stepper and in the two mapper stages before it is valid
// on the master side. Throughput: one item per cycle while ready is high; the line state
// takes one accumulator step per transfer.
// Ready is held back only when all three stages hold results the sink has not taken.
// Reset (synchronous, active low) drops any line in progress and empties the pipeline;
// orientation returns to landscape, panel size to 800 by 480.
`timescale 1ns / 1ps

module line_pixel_rasterizer import lpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [DIM_BITS-1:0]       i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // x_start, y_start, x_end, y_end, line_color, zero padding
    input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // pixel_row, pixel_col, pixel_address, pixel_color
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // off_panel
    output logic                      m_axis_tuser,
    output logic                      m_axis_tlast
);

    localparam int C = COORD_BITS;

    t_cfg r_cfg;

    logic                  pt_valid, pt_ready, pt_last;
    logic [C-1:0]          pt_x, pt_y;
    logic [COLOR_BITS-1:0] pt_color;
    logic [ROW_BITS-1:0]   out_row, out_col;
    logic [ADDR_BITS-1:0]  out_addr;
    logic [COLOR_BITS-1:0] out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation  <= ORIENT_LANDSCAPE;
            r_cfg.panel_width  <= WIDTH_RESET;
            r_cfg.panel_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ORIENT: begin
                    r_cfg.orientation <= i_cfg_data[0];
                end
                CFG_WIDTH: begin
                    r_cfg.panel_width <= i_cfg_data;
                end
                CFG_HEIGHT: begin
                    r_cfg.panel_height <= i_cfg_data;
                end
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    lpr_stepper #(
        .COORD_BITS(COORD_BITS)
    ) u_stepper (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_x_start (s_axis_tdata[C-1:0]),
        .i_y_start (s_axis_tdata[2*C-1:C]),
        .i_x_end   (s_axis_tdata[3*C-1:2*C]),
        .i_y_end   (s_axis_tdata[4*C-1:3*C]),
        .i_color   (s_axis_tdata[4*C+COLOR_BITS-1:4*C]),
        .o_valid   (pt_valid),
        .i_ready   (pt_ready),
        .o_x       (pt_x),
        .o_y       (pt_y),
        .o_last    (pt_last),
        .o_color   (pt_color)
    );

    lpr_mapper #(
        .COORD_BITS(COORD_BITS)
    ) u_mapper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (pt_valid),
        .o_ready (pt_ready),
        .i_x     (pt_x),
        .i_y     (pt_y),
        .i_last  (pt_last),
        .i_color (pt_color),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_row   (out_row),
        .o_col   (out_col),
        .o_addr  (out_addr),
        .o_color (out_color),
        .o_off   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'({out_color, out_addr, out_col, out_row});

endmodule

// ----- hdl/lpr_stepper.sv -----
// Line state and error-accumulator step; registers at most one point per transfer.
`timescale 1ns / 1ps

module lpr_stepper import lpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_BITS-1:0] i_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic                  o_last,
    output logic [COLOR_BITS-1:0] o_color
);

    logic                  r_active, n_active;
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [COORD_BITS-1:0] r_span_x, n_span_x;
    logic [COORD_BITS-1:0] r_span_y, n_span_y;
    logic                  r_neg_x, n_neg_x;
    logic                  r_neg_y, n_neg_y;
    logic [COORD_BITS-1:0] r_major, n_major;
    logic [COORD_BITS-1:0] r_err_x, n_err_x;
    logic [COORD_BITS-1:0] r_err_y, n_err_y;
    logic [COORD_BITS:0]   r_left, n_left;
    logic [COLOR_BITS-1:0] r_color, n_color;

    logic                  r_pv;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic                  r_plast;
    logic [COLOR_BITS-1:0] r_pcolor;

    logic                  accept;
    logic                  emit, emit_last;
    logic [COORD_BITS-1:0] emit_x, emit_y;
    logic                  start_neg_x, start_neg_y;
    logic [COORD_BITS-1:0] start_span_x, start_span_y, start_major;
    logic [COORD_BITS:0]   sum_x, sum_y, left_dec;
    logic                  hit_x, hit_y;

    assign o_ready = !r_pv || i_ready;
    assign accept  = i_valid && o_ready;

    assign start_neg_x  = i_x_end < i_x_start;
    assign start_neg_y  = i_y_end < i_y_start;
    assign start_span_x = start_neg_x ? i_x_start - i_x_end : i_x_end - i_x_start;
    assign start_span_y = start_neg_y ? i_y_start - i_y_end : i_y_end - i_y_start;
    assign start_major  = (start_span_x > start_span_y) ? start_span_x : start_span_y;

    // one accumulator step per axis
    assign sum_x    = {1'b0, r_err_x} + {1'b0, r_span_x};
    assign sum_y    = {1'b0, r_err_y} + {1'b0, r_span_y};
    assign hit_x    = sum_x > {1'b0, r_major};
    assign hit_y    = sum_y > {1'b0, r_major};
    assign left_dec = r_left - (COORD_BITS+1)'(1);

    always_comb begin
        n_active  = r_active;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_span_x  = r_span_x;
        n_span_y  = r_span_y;
        n_neg_x   = r_neg_x;
        n_neg_y   = r_neg_y;
        n_major   = r_major;
        n_err_x   = r_err_x;
        n_err_y   = r_err_y;
        n_left    = r_left;
        n_color   = r_color;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_x    = r_cur_x;
        emit_y    = r_cur_y;
        if (accept) begin
            if (i_mode == MODE_START) begin
                // start pixel goes out unmoved; error is primed by one step
                emit     = 1'b1;
                emit_x   = i_x_start;
                emit_y   = i_y_start;
                n_active = 1'b1;
                n_cur_x  = i_x_start;
                n_cur_y  = i_y_start;
                n_span_x = start_span_x;
                n_span_y = start_span_y;
                n_neg_x  = start_neg_x;
                n_neg_y  = start_neg_y;
                n_major  = start_major;
                n_err_x  = start_span_x;
                n_err_y  = start_span_y;
                n_left   = {1'b0, start_major} + (COORD_BITS+1)'(1);
                n_color  = i_color;
            end else if (r_active) begin
                emit = 1'b1;
                if (left_dec == '0) begin
                    emit_last = 1'b1;
                    n_active  = 1'b0;
                    n_left    = '0;
                end else begin
                    n_left = left_dec;
                    if (hit_x) begin
                        n_err_x = COORD_BITS'(sum_x - {1'b0, r_major});
                        n_cur_x = r_neg_x ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
                    end else begin
                        n_err_x = sum_x[COORD_BITS-1:0];
                    end
                    if (hit_y) begin
                        n_err_y = COORD_BITS'(sum_y - {1'b0, r_major});
                        n_cur_y = r_neg_y ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
                    end else begin
                        n_err_y = sum_y[COORD_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
            r_pv     <= 1'b0;
        end else begin
            r_active <= n_active;
            r_left   <= n_left;
            if (accept) begin
                r_pv <= emit;
            end else if (i_ready) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_span_x <= n_span_x;
        r_span_y <= n_span_y;
        r_neg_x  <= n_neg_x;
        r_neg_y  <= n_neg_y;
        r_major  <= n_major;
        r_err_x  <= n_err_x;
        r_err_y  <= n_err_y;
        r_color  <= n_color;
        if (accept) begin
            r_px     <= emit_x;
            r_py     <= emit_y;
            r_plast  <= emit_last;
            r_pcolor <= (i_mode == MODE_START) ? i_color : r_color;
        end
    end

    assign o_valid = r_pv;
    assign o_x     = r_px;
    assign o_y     = r_py;
    assign o_last  = r_plast;
    assign o_color = r_pcolor;

    a_idle_advance_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_ADVANCE && !r_active) |=> !r_pv)
        else $error("advance with no line produced a point");

    a_active_has_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != '0))
        else $error("active line with no pixels left");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_ADVANCE && r_active && r_left == (COORD_BITS+1)'(1))
        |=> (!r_active && r_pv && r_plast))
        else $error("final pixel did not close the line");

    a_start_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_START) |=> (r_active && r_pv && !r_plast))
        else $error("start pixel marked last or line not opened");

endmodule

// ----- hdl/lpr_mapper.sv -----
// Orientation mapping, bounds check and row-major address, two register stages.
`timescale 1ns / 1ps

module lpr_mapper import lpr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_last,
    input  logic [COLOR_BITS-1:0] i_color,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ROW_BITS-1:0]   o_row,
    output logic [ROW_BITS-1:0]   o_col,
    output logic [ADDR_BITS-1:0]  o_addr,
    output logic [COLOR_BITS-1:0] o_color,
    output logic                  o_off,
    output logic                  o_last
);

    localparam int RW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;
    localparam int PW = ROW_BITS + DIM_BITS;

    logic signed [RW-1:0] x_s, y_s, height_s, width_s, row_s, col_s;
    logic                 off;
    logic                 ready_out;
    logic [PW-1:0]        prod, addr_sum;

    logic                  r_v2, r_v3;
    logic [ROW_BITS-1:0]   r_row2, r_col2, r_row3, r_col3;
    logic                  r_off2, r_off3, r_last2, r_last3;
    logic [COLOR_BITS-1:0] r_color2, r_color3;
    logic [ADDR_BITS-1:0]  r_addr3;

    assign ready_out = !r_v3 || i_ready;
    assign o_ready   = !r_v2 || ready_out;

    assign x_s      = $signed(RW'(i_x));
    assign y_s      = $signed(RW'(i_y));
    assign height_s = $signed(RW'(i_cfg.panel_height));
    assign width_s  = $signed(RW'(i_cfg.panel_width));
    // rotated: row counts down from the bottom and may go negative
    assign row_s = (i_cfg.orientation == ORIENT_LANDSCAPE) ? y_s
                 : height_s - x_s - $signed(RW'(1));
    assign col_s = (i_cfg.orientation == ORIENT_LANDSCAPE) ? x_s : y_s;
    assign off   = row_s[RW-1] || (row_s >= height_s) || (col_s >= width_s);

    assign prod     = PW'(r_row2) * PW'(i_cfg.panel_width);
    assign addr_sum = prod + PW'(r_col2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready_out) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_row2   <= row_s[ROW_BITS-1:0];
            r_col2   <= col_s[ROW_BITS-1:0];
            r_off2   <= off;
            r_last2  <= i_last;
            r_color2 <= i_color;
        end
        if (ready_out) begin
            r_row3   <= r_row2;
            r_col3   <= r_col2;
            r_addr3  <= addr_sum[ADDR_BITS-1:0];
            r_off3   <= r_off2;
            r_last3  <= r_last2;
            r_color3 <= r_color2;
        end
    end

    assign o_valid = r_v3;
    assign o_row   = r_row3;
    assign o_col   = r_col3;
    assign o_addr  = r_addr3;
    assign o_color = r_color3;
    assign o_off   = r_off3;
    assign o_last  = r_last3;

endmodule

// ----- sim/pixel_write_checker.sv -----
// Line rasteriser checker: tracks both stream channels, predicts pixel writes and compares them.
`timescale 1ns / 1ps

module pixel_write_checker import lpr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    // x_start, y_start, x_end, y_end, line_color
    input  logic [((4*COORD_BITS_DEF+COLOR_BITS+7)/8)*8-1:0] i_s_tdata,
    // mode
    input  logic                    i_s_tuser,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    // pixel_row, pixel_col, pixel_address, pixel_color
    input  logic [OUT_TDATA_BITS-1:0] i_m_tdata,
    // off_panel
    input  logic                    i_m_tuser,
    input  logic                    i_m_tlast,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_off_seen
);

    localparam int CB = COORD_BITS_DEF;
    localparam logic signed [1:0] STEP_NONE = 2'sd0;
    localparam logic signed [1:0] STEP_UP   = 2'sd1;
    localparam logic signed [1:0] STEP_DOWN = -2'sd1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [ROW_BITS-1:0]   col;
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] color;
        logic                  off;
        logic                  last;
    } t_pixel_write;

    // Register copy
    logic                orient;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;

    // Line walker state
    logic                  line_on;
    logic [CB-1:0]         cur_x, cur_y;
    logic [CB-1:0]         span_x, span_y, major;
    logic signed [1:0]     step_x, step_y;
    logic [CB:0]           err_x, err_y, left;
    logic [COLOR_BITS-1:0] line_color;

    t_pixel_write pending_pixels[$];
    int fails    = 0;
    int checked  = 0;
    int off_seen = 0;
    int pend_n   = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend_n;
    assign o_checked    = checked;
    assign o_off_seen   = off_seen;

    function automatic void clear_walker();
        orient     = ORIENT_LANDSCAPE;
        width      = WIDTH_RESET;
        height     = HEIGHT_RESET;
        line_on    = 1'b0;
        cur_x      = '0;
        cur_y      = '0;
        span_x     = '0;
        span_y     = '0;
        major      = '0;
        step_x     = STEP_NONE;
        step_y     = STEP_NONE;
        err_x      = '0;
        err_y      = '0;
        left       = '0;
        line_color = '0;
    endfunction

    // Map the current point to the frame buffer; rows below zero wrap in ten bits.
    function automatic t_pixel_write pixel_here(input logic last);
        t_pixel_write px;
        int           row_i;
        int           col_i;
        logic [31:0]  prod;
        if (orient == ORIENT_LANDSCAPE) begin
            row_i = int'(cur_y);
            col_i = int'(cur_x);
        end else begin
            row_i = int'(height) - 1 - int'(cur_x);
            col_i = int'(cur_y);
        end
        px.row   = row_i[ROW_BITS-1:0];
        px.col   = col_i[ROW_BITS-1:0];
        prod     = 32'(px.row) * 32'(width) + 32'(px.col);
        px.addr  = prod[ADDR_BITS-1:0];
        px.color = line_color;
        px.off   = (row_i < 0) || (row_i >= int'(height)) || (col_i >= int'(width));
        px.last  = last;
        return px;
    endfunction

    function automatic void accumulate_error();
        logic [CB+1:0] ex;
        logic [CB+1:0] ey;
        ex = {1'b0, err_x} + span_x;
        ey = {1'b0, err_y} + span_y;
        if (ex > major) begin
            ex    = ex - major;
            cur_x = cur_x + {{(CB-2){step_x[1]}}, step_x};
        end
        if (ey > major) begin
            ey    = ey - major;
            cur_y = cur_y + {{(CB-2){step_y[1]}}, step_y};
        end
        err_x = ex[CB:0];
        err_y = ey[CB:0];
    endfunction

    function automatic t_pixel_write begin_line(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                                                input logic [CB-1:0] x1, input logic [CB-1:0] y1,
                                                input logic [COLOR_BITS-1:0] color);
        t_pixel_write px;
        int dx;
        int dy;
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        step_x     = (dx > 0) ? STEP_UP : ((dx < 0) ? STEP_DOWN : STEP_NONE);
        step_y     = (dy > 0) ? STEP_UP : ((dy < 0) ? STEP_DOWN : STEP_NONE);
        span_x     = CB'((dx < 0) ? -dx : dx);
        span_y     = CB'((dy < 0) ? -dy : dy);
        major      = (span_x > span_y) ? span_x : span_y;
        cur_x      = x0;
        cur_y      = y0;
        err_x      = '0;
        err_y      = '0;
        line_color = color;
        left       = {1'b0, major} + 1'b1;
        line_on    = 1'b1;
        px = pixel_here(1'b0);
        accumulate_error();
        return px;
    endfunction

    // Returns 1 when the advance produces a write.
    function automatic logic advance_line(output t_pixel_write px);
        logic last;
        px = '0;
        if (!line_on)
            return 1'b0;
        left = left - 1'b1;
        last = (left == 0);
        px   = pixel_here(last);
        if (last)
            line_on = 1'b0;
        else
            accumulate_error();
        return 1'b1;
    endfunction

    initial clear_walker();

    always @(posedge i_clk) begin : watch
        t_pixel_write exp_px;
        t_pixel_write got_px;
        logic         produced;
        if (!i_rst_n) begin
            clear_walker();
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ORIENT: orient = i_cfg_data[0];
                    CFG_WIDTH:  width  = i_cfg_data;
                    CFG_HEIGHT: height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == MODE_START) begin
                    exp_px   = begin_line(i_s_tdata[CB-1:0], i_s_tdata[2*CB-1:CB],
                                          i_s_tdata[3*CB-1:2*CB], i_s_tdata[4*CB-1:3*CB],
                                          i_s_tdata[4*CB+COLOR_BITS-1:4*CB]);
                    produced = 1'b1;
                end else begin
                    produced = advance_line(exp_px);
                end
                if (produced)
                    pending_pixels.push_back(exp_px);
            end
            if (i_m_tvalid && i_m_tready) begin
                got_px.row   = i_m_tdata[ROW_BITS-1:0];
                got_px.col   = i_m_tdata[2*ROW_BITS-1:ROW_BITS];
                got_px.addr  = i_m_tdata[2*ROW_BITS+ADDR_BITS-1:2*ROW_BITS];
                got_px.color = i_m_tdata[2*ROW_BITS+ADDR_BITS+COLOR_BITS-1:2*ROW_BITS+ADDR_BITS];
                got_px.off   = i_m_tuser;
                got_px.last  = i_m_tlast;
                if (pending_pixels.size() == 0) begin
                    if (fails < REPORT_LIMIT)
                        $display("Unexpected pixel write: row %0d col %0d addr %h color %h",
                                 got_px.row, got_px.col, got_px.addr, got_px.color);
                    fails++;
                end else begin
                    exp_px = pending_pixels.pop_front();
                    if (got_px.row !== exp_px.row || got_px.col !== exp_px.col ||
                        got_px.addr !== exp_px.addr || got_px.color !== exp_px.color ||
                        got_px.off !== exp_px.off || got_px.last !== exp_px.last) begin
                        if (fails < REPORT_LIMIT) begin
                            $display("Pixel mismatch, expected: row %0d col %0d addr %h color %h off %b last %b",
                                     exp_px.row, exp_px.col, exp_px.addr, exp_px.color,
                                     exp_px.off, exp_px.last);
                            $display("                  actual: row %0d col %0d addr %h color %h off %b last %b",
                                     got_px.row, got_px.col, got_px.addr, got_px.color,
                                     got_px.off, got_px.last);
                        end
                        fails++;
                    end
                    checked++;
                    if (got_px.off)
                        off_seen++;
                end
            end
        end
        pend_n = pending_pixels.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the line rasteriser: clock, reset, line commands, sink stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import lpr_pkg::*;

    localparam int IN_BITS       = ((4*COORD_BITS_DEF+COLOR_BITS+7)/8)*8;
    localparam int CB            = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 105;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int COORD_MAX     = (1 << CB) - 1;
    localparam logic                    ORIENT_ROTATED = ~ORIENT_LANDSCAPE;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE      = CFG_IDX_BITS'(3);
    localparam logic [DIM_BITS-1:0]     DIM_MAX        = '1;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [DIM_BITS-1:0]       i_cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_BITS-1:0]        s_axis_tdata;
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      m_axis_tlast;

    int fail_count;
    int pending;
    int pixels_checked;
    int off_seen;
    int cycles       = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int settings_run = 0;
    int hold_req     = 0;
    int hold_done    = 0;

    line_pixel_rasterizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pixel_write_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (pixels_checked),
        .o_off_seen   (off_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d writes outstanding", pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Sink: stretches of always-ready, random ready and short stalls; long hold-off on request.
    initial begin : sink
        int kind;
        int seg;
        m_axis_tready = 1'b0;
        forever begin
            if (hold_req != hold_done) begin
                hold_done++;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                end
            end else begin
                kind = $urandom_range(0, 3);
                seg  = (kind == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
                repeat (seg) begin
                    @(negedge i_clk);
                    case (kind)
                        0:       m_axis_tready = 1'b1;
                        3:       m_axis_tready = 1'b0;
                        default: m_axis_tready = ($urandom_range(0, 9) < 6);
                    endcase
                end
            end
        end
    end

    function automatic int line_span(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                                     input logic [CB-1:0] x1, input logic [CB-1:0] y1);
        int dx;
        int dy;
        dx = (x1 > x0) ? int'(x1 - x0) : int'(x0 - x1);
        dy = (y1 > y0) ? int'(y1 - y0) : int'(y0 - y1);
        return (dx > dy) ? dx : dy;
    endfunction

    // Pick an endpoint at distance d from c, staying on the coordinate range.
    function automatic logic [CB-1:0] near_point(input logic [CB-1:0] c, input int d);
        int up;
        int down;
        up   = int'(c) + d;
        down = int'(c) - d;
        if ($urandom_range(0, 1) == 1)
            return CB'((up <= COORD_MAX) ? up : down);
        return CB'((down >= 0) ? down : up);
    endfunction

    task automatic send_cmd(input logic mode, input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                            input logic [CB-1:0] x1, input logic [CB-1:0] y1,
                            input logic [COLOR_BITS-1:0] color);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = {$urandom, $urandom};
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = IN_BITS'({color, y1, x1, y0, x0});
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    // Start a line and step it n_adv times; advances past the end are not counted.
    task automatic draw_line(input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                             input logic [CB-1:0] x1, input logic [CB-1:0] y1,
                             input logic [COLOR_BITS-1:0] color, input int n_adv);
        int span;
        span = line_span(x0, y0, x1, y1);
        send_cmd(MODE_START, x0, y0, x1, y1, color);
        items_sent++;
        for (int i = 0; i < n_adv; i++) begin
            send_cmd(MODE_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                     COLOR_BITS'($urandom));
            if (i <= span)
                items_sent++;
        end
    endtask

    // Drop valid, drain every outstanding write and let idle clocks clear the pipeline.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic configure(input logic orient, input logic [DIM_BITS-1:0] w,
                             input logic [DIM_BITS-1:0] h);
        set_reg(CFG_ORIENT, DIM_BITS'(orient));
        set_reg(CFG_WIDTH, w);
        set_reg(CFG_HEIGHT, h);
        settings_run++;
    endtask

    task automatic random_phase(input int quota);
        int             first;
        int             pick;
        int             dx;
        int             dy;
        logic [CB-1:0]  x0, y0, x1, y1;
        first = items_sent;
        while (items_sent - first < quota) begin
            pick = $urandom_range(0, 99);
            x0   = CB'($urandom);
            y0   = CB'($urandom);
            if (pick < 70) begin
                // complete line, sometimes followed by idle advances
                dx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
                dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
                if ($urandom_range(0, 5) == 0)
                    dx = 0;
                else if ($urandom_range(0, 5) == 0)
                    dy = 0;
                x1 = near_point(x0, dx);
                y1 = near_point(y0, dy);
                draw_line(x0, y0, x1, y1, COLOR_BITS'($urandom),
                          line_span(x0, y0, x1, y1) + 1 +
                          (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0));
            end else if (pick < 85) begin
                // long line, abandoned by the next start
                draw_line(x0, y0, CB'($urandom), CB'($urandom), COLOR_BITS'($urandom),
                          $urandom_range(0, 6));
            end else if (pick < 92) begin
                draw_line(x0, y0, CB'($urandom), CB'($urandom), COLOR_BITS'($urandom), 0);
            end else begin
                send_cmd(MODE_ADVANCE, x0, y0, CB'($urandom), CB'($urandom),
                         COLOR_BITS'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ORIENT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_START;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        settings_run = 1;

        // Directed: idle advance, zero-length line, corner colours, abandon, off panel
        send_cmd(MODE_ADVANCE, CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX),
                 '1);
        draw_line('0, '0, '0, '0, '0, 3);
        draw_line(CB'(COORD_MAX), CB'(COORD_MAX), CB'(COORD_MAX - 3), CB'(COORD_MAX - 1), '1, 4);
        draw_line(CB'(900), CB'(5), CB'(5), CB'(9), 24'hA5A5A5, 2);
        draw_line(CB'(10), CB'(2), CB'(10), CB'(6), 24'h5A5A5A, 5);
        settle();
        // rotated on a one-row panel: rows fall below zero
        configure(ORIENT_ROTATED, DIM_BITS'(1024), DIM_BITS'(1));
        draw_line(CB'(3), CB'(0), CB'(0), CB'(3), 24'h123456, 4);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: configure(ORIENT_LANDSCAPE, DIM_BITS'(1024), DIM_BITS'(1024));
                1: configure(ORIENT_ROTATED, WIDTH_RESET, HEIGHT_RESET);
                2: configure(ORIENT_LANDSCAPE, DIM_BITS'(1), DIM_BITS'(1));
                3: configure(ORIENT_ROTATED, DIM_BITS'(1024), DIM_BITS'(1));
                4: begin
                    set_reg(CFG_SPARE, DIM_MAX);
                    configure(ORIENT_LANDSCAPE, '0, DIM_MAX);
                end
                default: configure(ORIENT_ROTATED, DIM_BITS'($urandom_range(1, 1024)),
                                   DIM_BITS'($urandom_range(1, 1024)));
            endcase
            if (ph == 2) begin
                // hold the sink off while commands keep coming, so the input stalls
                random_phase(20);
                hold_req++;
                random_phase(PHASE_ITEMS - 20);
            end else begin
                random_phase(PHASE_ITEMS);
            end
        end
        settle();

        $display("Covered %0d line commands over %0d register settings, both orientations.",
                 items_sent, settings_run);
        $display("Checked %0d pixel writes, %0d of them off panel.", pixels_checked, off_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
